// ===== hdl/voxel_brick_map_insert_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel brick map insert unit assertion macros
// Shared assertion forms for the insert unit, clocked on clk and held off
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VOXEL_BRICK_MAP_INSERT_UNIT_DEFINES_SVH
`define VOXEL_BRICK_MAP_INSERT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VBM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/vbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel brick map package
// Constants, codes and types shared by the front end, request queue and
// back end of the voxel brick map insert unit.
// ----------------------------------------------------------------------------
package vbm_pkg;

	localparam int GRID_CELLS_DFLT  = 4096;
	localparam int POOL_BRICKS_DFLT = 1024;

	localparam int BRICK_EDGE  = 8;
	localparam int BRICK_SHIFT = $clog2(BRICK_EDGE);
	localparam int COORD_BITS  = 10;
	localparam int GRID_REG_W  = 5;
	localparam int BCOORD_W    = COORD_BITS - BRICK_SHIFT;
	localparam int T_W         = BCOORD_W + GRID_REG_W;
	localparam int CELL_FULL_W = T_W + GRID_REG_W;
	localparam int FINE_W      = 3 * BRICK_SHIFT;
	localparam int BRICK_VOX   = BRICK_EDGE * BRICK_EDGE * BRICK_EDGE;
	localparam int COLOR_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int SLOT_OUT_W  = 10;
	localparam int TALLY_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [GRID_REG_W-1:0] GRID_RESET = GRID_REG_W'(16);

	localparam logic [CFG_IDX_W-1:0] REG_GRID_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = CFG_IDX_W'(2);

	localparam logic [STATUS_W-1:0] ST_STORED = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_BOUNDS = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_FULL   = STATUS_W'(2);

	typedef struct packed {
		logic                   oob;
		logic [CELL_FULL_W-1:0] grid_idx;
		logic [FINE_W-1:0]      fine;
		logic [COLOR_W-1:0]     color;
	} vbm_req_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_READ,
		BK_RESOLVE
	} vbm_bk_state_t;

endpackage

// ===== hdl/vbm_front.sv =====
// ----------------------------------------------------------------------------
// Voxel brick map front end
// Holds the grid size registers, accepts voxel write requests, splits the
// coordinates and works out the flattened brick cell and its bounds check.
// ----------------------------------------------------------------------------
module vbm_front #(
	parameter int GRID_CELLS = vbm_pkg::GRID_CELLS_DFLT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [vbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vbm_pkg::GRID_REG_W-1:0]   cfg_data,
	input  logic                             clearing,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [vbm_pkg::COORD_BITS-1:0]   voxel_x,
	input  logic [vbm_pkg::COORD_BITS-1:0]   voxel_y,
	input  logic [vbm_pkg::COORD_BITS-1:0]   voxel_z,
	input  logic [vbm_pkg::COLOR_W-1:0]      voxel_color,
	input  logic                             q_full,
	output logic                             q_push,
	output vbm_pkg::vbm_req_t                q_entry
);
	import vbm_pkg::*;

	logic [GRID_REG_W-1:0] gx_q, gy_q, gz_q;

	logic [BCOORD_W-1:0]    cx_in, cy_in, cz_in;
	logic                   ib_in;
	logic [T_W-1:0]         t_in;
	logic [FINE_W-1:0]      fine_in;

	logic                   v_s1;
	logic [BCOORD_W-1:0]    cx_s1;
	logic                   ib_s1;
	logic [T_W-1:0]         t_s1;
	logic [FINE_W-1:0]      fine_s1;
	logic [COLOR_W-1:0]     color_s1;
	logic [CELL_FULL_W-1:0] cell_s1;
	logic                   take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q <= GRID_RESET;
			gy_q <= GRID_RESET;
			gz_q <= GRID_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GRID_X: gx_q <= cfg_data;
				REG_GRID_Y: gy_q <= cfg_data;
				REG_GRID_Z: gz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cx_in   = voxel_x[COORD_BITS-1:BRICK_SHIFT];
	assign cy_in   = voxel_y[COORD_BITS-1:BRICK_SHIFT];
	assign cz_in   = voxel_z[COORD_BITS-1:BRICK_SHIFT];
	assign ib_in   = (cx_in < BCOORD_W'(gx_q)) && (cy_in < BCOORD_W'(gy_q)) &&
		(cz_in < BCOORD_W'(gz_q));
	assign t_in    = T_W'(cy_in) + T_W'(gy_q) * T_W'(cz_in);
	assign fine_in = {voxel_z[BRICK_SHIFT-1:0], voxel_y[BRICK_SHIFT-1:0],
		voxel_x[BRICK_SHIFT-1:0]};

	assign cell_s1  = CELL_FULL_W'(cx_s1) + CELL_FULL_W'(gx_q) * CELL_FULL_W'(t_s1);
	assign q_push   = v_s1 && !q_full;
	assign in_ready = !clearing && (!v_s1 || q_push);
	assign take     = in_valid && in_ready;

	always_comb begin
		q_entry.oob      = !ib_s1 || (cell_s1 >= CELL_FULL_W'(GRID_CELLS));
		q_entry.grid_idx = cell_s1;
		q_entry.fine     = fine_s1;
		q_entry.color    = color_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cx_s1    <= cx_in;
			ib_s1    <= ib_in;
			t_s1     <= t_in;
			fine_s1  <= fine_in;
			color_s1 <= voxel_color;
		end
	end

endmodule

// ===== hdl/vbm_queue.sv =====
// ----------------------------------------------------------------------------
// Voxel brick map request queue
// A short first-in first-out queue of classified requests between the front
// end and the back end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module vbm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vbm_pkg::vbm_req_t din,
	input  logic              pop,
	output vbm_pkg::vbm_req_t dout,
	output logic              full,
	output logic              empty
);
	import vbm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	vbm_req_t         slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/vbm_back.sv =====
// ----------------------------------------------------------------------------
// Voxel brick map back end
// Owns the grid table, the brick allocator, the voxel store and the write
// count. Each request takes a table read and then a resolve and write-back.
// ----------------------------------------------------------------------------
module vbm_back #(
	parameter int GRID_CELLS  = vbm_pkg::GRID_CELLS_DFLT,
	parameter int POOL_BRICKS = vbm_pkg::POOL_BRICKS_DFLT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vbm_pkg::vbm_req_t               req,
	input  logic                            req_valid,
	output logic                            req_pop,
	output logic                            clearing,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vbm_pkg::STATUS_W-1:0]    status,
	output logic [vbm_pkg::SLOT_OUT_W-1:0]  brick_slot,
	output logic                            new_brick,
	output logic [vbm_pkg::FINE_W-1:0]      fine_offset,
	output logic [vbm_pkg::TALLY_W-1:0]     total_voxels
);
	import vbm_pkg::*;

	localparam int CELL_W    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam int SLOT_W    = (POOL_BRICKS > 1) ? $clog2(POOL_BRICKS) : 1;
	localparam int USED_W    = $clog2(POOL_BRICKS + 1);
	localparam int ENT_W     = SLOT_W + 1;
	localparam int VADDR_W   = SLOT_W + FINE_W;
	localparam int VOX_DEPTH = POOL_BRICKS * BRICK_VOX;

	logic [ENT_W-1:0]   grid_mem [GRID_CELLS];
	logic [COLOR_W-1:0] vox_mem  [VOX_DEPTH];

	vbm_bk_state_t      state_q, state_d;
	logic [CELL_W-1:0]  clr_q;
	logic [USED_W-1:0]  bricks_q;
	logic [TALLY_W-1:0] tally_q, tally_d;
	vbm_req_t           head_q;
	logic [ENT_W-1:0]   rd_q;

	logic               out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic               out_new_q;
	logic [FINE_W-1:0]  out_fine_q;
	logic [TALLY_W-1:0] out_tally_q;

	logic               tbl_re, tbl_we, vox_we, fire;
	logic [CELL_W-1:0]  tbl_waddr;
	logic [ENT_W-1:0]   tbl_wdata;

	logic               hit, pool_full, ok, fresh;
	logic [SLOT_W-1:0]  new_slot;
	logic [STATUS_W-1:0] res_status;

	assign hit       = rd_q[SLOT_W];
	assign pool_full = (bricks_q == USED_W'(POOL_BRICKS));

	always_comb begin
		if (head_q.oob) begin
			res_status = ST_BOUNDS;
		end else if (!hit && pool_full) begin
			res_status = ST_FULL;
		end else begin
			res_status = ST_STORED;
		end
	end

	assign ok       = (res_status == ST_STORED);
	assign fresh    = ok && !hit;
	assign new_slot = hit ? rd_q[SLOT_W-1:0] : bricks_q[SLOT_W-1:0];
	assign tally_d  = (ok && (tally_q != '1)) ? tally_q + 1'b1 : tally_q;

	always_comb begin
		state_d   = state_q;
		req_pop   = 1'b0;
		tbl_re    = 1'b0;
		tbl_we    = 1'b0;
		vox_we    = 1'b0;
		fire      = 1'b0;
		tbl_waddr = head_q.grid_idx[CELL_W-1:0];
		tbl_wdata = {1'b1, new_slot};
		unique case (state_q)
			BK_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
				tbl_wdata = '0;
				if (clr_q == CELL_W'(GRID_CELLS - 1)) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (req_valid) begin
					req_pop = 1'b1;
					tbl_re  = 1'b1;
					state_d = BK_RESOLVE;
				end
			end
			BK_RESOLVE: begin
				if (!out_valid_q || out_ready) begin
					fire    = 1'b1;
					vox_we  = ok;
					tbl_we  = fresh;
					state_d = BK_READ;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			grid_mem[tbl_waddr] <= tbl_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_re) begin
			rd_q <= grid_mem[req.grid_idx[CELL_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (vox_we) begin
			vox_mem[VADDR_W'({new_slot, head_q.fine})] <= head_q.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			bricks_q    <= '0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				tally_q     <= tally_d;
				if (fresh) begin
					bricks_q <= bricks_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			head_q <= req;
		end
		if (fire) begin
			out_status_q <= res_status;
			out_slot_q   <= ok ? SLOT_OUT_W'(new_slot) : '0;
			out_new_q    <= fresh;
			out_fine_q   <= head_q.fine;
			out_tally_q  <= tally_d;
		end
	end

	assign clearing     = (state_q == BK_CLEAR);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign brick_slot   = out_slot_q;
	assign new_brick    = out_new_q;
	assign fine_offset  = out_fine_q;
	assign total_voxels = out_tally_q;

endmodule

// ===== hdl/voxel_brick_map_insert_unit.sv =====
// ----------------------------------------------------------------------------
// Voxel brick map insert unit
// Inserts voxel writes into a sparse map of 8x8x8 bricks, allocating pool
// slots on first touch of a grid cell and counting stored voxels.
// ----------------------------------------------------------------------------
// Requests arrive on the in_valid/in_ready channel as x, y, z and a colour;
// one result per request leaves on out_valid/out_ready with the status, the
// pool slot, the new-brick flag, the offset inside the brick and the count
// of stored voxels. The grid size registers are to be written by the user
// through cfg_wr_en, cfg_index and cfg_data only while no request is in
// flight; the block does not enforce this. The back end spends a grid table
// read state and then an allocation and write-back state on each request,
// so it takes no new request before it is through with the last one.
// Each result leaves through the output register.
// After reset the grid table is swept clear, one entry a cycle, over all
// GRID_CELLS entries (4096 by default); in_ready stays low throughout, while
// configuration writes are taken as usual.
// When the receiver stalls, the result is held in the output register and
// up to three further requests gather in the front stage and the queue
// before in_ready falls.
// ----------------------------------------------------------------------------
`include "voxel_brick_map_insert_unit_defines.svh"

module voxel_brick_map_insert_unit #(
	parameter int GRID_CELLS  = vbm_pkg::GRID_CELLS_DFLT,
	parameter int POOL_BRICKS = vbm_pkg::POOL_BRICKS_DFLT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [vbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vbm_pkg::GRID_REG_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [vbm_pkg::COORD_BITS-1:0]  voxel_x,
	input  logic [vbm_pkg::COORD_BITS-1:0]  voxel_y,
	input  logic [vbm_pkg::COORD_BITS-1:0]  voxel_z,
	input  logic [vbm_pkg::COLOR_W-1:0]     voxel_color,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vbm_pkg::STATUS_W-1:0]    status,
	output logic [vbm_pkg::SLOT_OUT_W-1:0]  brick_slot,
	output logic                            new_brick,
	output logic [vbm_pkg::FINE_W-1:0]      fine_offset,
	output logic [vbm_pkg::TALLY_W-1:0]     total_voxels
);
	import vbm_pkg::*;

	vbm_req_t q_in, q_out;
	logic     q_push, q_pop, q_full, q_empty;
	logic     clearing;

	vbm_front #(
		.GRID_CELLS(GRID_CELLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.clearing   (clearing),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.voxel_x    (voxel_x),
		.voxel_y    (voxel_y),
		.voxel_z    (voxel_z),
		.voxel_color(voxel_color),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_in)
	);

	vbm_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.pop   (q_pop),
		.dout  (q_out),
		.full  (q_full),
		.empty (q_empty)
	);

	vbm_back #(
		.GRID_CELLS (GRID_CELLS),
		.POOL_BRICKS(POOL_BRICKS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (q_out),
		.req_valid   (!q_empty),
		.req_pop     (q_pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.brick_slot  (brick_slot),
		.new_brick   (new_brick),
		.fine_offset (fine_offset),
		.total_voxels(total_voxels)
	);

	`VBM_ASSERT_SAME(a_no_accept_while_clearing, clearing, !in_ready, "request taken during table clear")
	`VBM_ASSERT_SAME(a_pop_needs_entry, q_pop, !q_empty, "back end popped an empty queue")
	`VBM_ASSERT_SAME(a_new_brick_stored, out_valid && new_brick, status == ST_STORED, "new brick on a rejected write")
	`VBM_ASSERT_SAME(a_reject_clean, out_valid && (status != ST_STORED), (brick_slot == '0) && !new_brick, "rejected write carries a slot")
	`VBM_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(total_voxels), "stalled result changed")

endmodule

// ===== tb/sv/tb_voxel_brick_map_insert_unit.sv =====
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// Voxel brick map insert unit testbench
// Sends voxel write requests through the insert unit under several grid
// sizes and compares every result with a cycle-free model of the grid
// table, brick pool and voxel count, or with a hand-written one. A short
// table of hand-picked requests comes first, followed by random requests
// that mostly touch fresh or recent bricks, until the pool fills and overflows.
// ----------------------------------------------------------------------------
module tb_voxel_brick_map_insert_unit;
	import vbm_pkg::*;

	localparam int GRID_CELLS  = GRID_CELLS_DFLT;
	localparam int POOL_BRICKS = POOL_BRICKS_DFLT;
	localparam int BRICK_TOP   = (1 << BCOORD_W) - 1;
	localparam int N_CASES     = 20;
	localparam int N_PHASES    = 7;
	localparam int FILL_PHASE  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	typedef enum int {
		IDLE_RECV_HEAVY,
		IDLE_SEND_HEAVY,
		IDLE_NONE
	} idle_mode_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  fresh;
		logic [FINE_W-1:0]     fine;
		logic [TALLY_W-1:0]    tally;
	} insert_result_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
	} voxel_pos_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [COLOR_W-1:0]    color;
		logic                  by_hand;
		insert_result_t        res;
	} voxel_case_t;

	localparam insert_result_t NO_RESULT = '0;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [GRID_REG_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [COORD_BITS-1:0] voxel_x     = '0;
	logic [COORD_BITS-1:0] voxel_y     = '0;
	logic [COORD_BITS-1:0] voxel_z     = '0;
	logic [COLOR_W-1:0]    voxel_color = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] brick_slot;
	logic                  new_brick;
	logic [FINE_W-1:0]     fine_offset;
	logic [TALLY_W-1:0]    total_voxels;

	int unsigned           grid_w = 16;
	int unsigned           grid_h = 16;
	int unsigned           grid_d = 16;
	bit                    cell_taken [GRID_CELLS];
	logic [SLOT_OUT_W-1:0] cell_slot [GRID_CELLS];
	int unsigned           slots_used   = 0;
	logic [TALLY_W-1:0]    stored_count = '0;

	insert_result_t pending_results[$];
	voxel_pos_t     recent_voxels[$];
	int             errors         = 0;
	int             send_idle_pct  = 0;
	int             recv_stall_pct = 0;

	voxel_case_t directed_cases [N_CASES] = '{
		'{10'd0,    10'd0,    10'd0,    32'h0000_0000, 1'b1, '{ST_STORED, 10'd0, 1'b1, 9'd0,   32'd1}},
		'{10'd7,    10'd7,    10'd7,    32'hFFFF_FFFF, 1'b1, '{ST_STORED, 10'd0, 1'b0, 9'd511, 32'd2}},
		'{10'd127,  10'd127,  10'd127,  32'hA5A5_A5A5, 1'b1, '{ST_STORED, 10'd1, 1'b1, 9'd511, 32'd3}},
		'{10'd128,  10'd0,    10'd0,    32'h5A5A_5A5A, 1'b1, '{ST_BOUNDS, 10'd0, 1'b0, 9'd0,   32'd3}},
		'{10'd0,    10'd128,  10'd0,    32'h1234_5678, 1'b1, '{ST_BOUNDS, 10'd0, 1'b0, 9'd0,   32'd3}},
		'{10'd0,    10'd0,    10'd128,  32'h8765_4321, 1'b1, '{ST_BOUNDS, 10'd0, 1'b0, 9'd0,   32'd3}},
		'{10'd1023, 10'd1023, 10'd1023, 32'hDEAD_BEEF, 1'b1, '{ST_BOUNDS, 10'd0, 1'b0, 9'd511, 32'd3}},
		'{10'd512,  10'd0,    10'd0,    32'h0000_0000, 1'b1, '{ST_BOUNDS, 10'd0, 1'b0, 9'd0,   32'd3}},
		'{10'd0,    10'd512,  10'd0,    32'hFFFF_FFFF, 1'b1, '{ST_BOUNDS, 10'd0, 1'b0, 9'd0,   32'd3}},
		'{10'd0,    10'd0,    10'd512,  32'h0F0F_0F0F, 1'b1, '{ST_BOUNDS, 10'd0, 1'b0, 9'd0,   32'd3}},
		'{10'd8,    10'd0,    10'd0,    32'h0101_0101, 1'b1, '{ST_STORED, 10'd2, 1'b1, 9'd0,   32'd4}},
		'{10'd9,    10'd1,    10'd2,    32'h8000_0000, 1'b0, NO_RESULT},
		'{10'd127,  10'd0,    10'd0,    32'h7FFF_FFFF, 1'b1, '{ST_STORED, 10'd3, 1'b1, 9'd7,   32'd6}},
		'{10'd0,    10'd127,  10'd0,    32'hF0F0_F0F0, 1'b0, NO_RESULT},
		'{10'd0,    10'd0,    10'd127,  32'h3C3C_3C3C, 1'b0, NO_RESULT},
		'{10'h055,  10'h02A,  10'h055,  32'h5555_5555, 1'b0, NO_RESULT},
		'{10'h2AA,  10'h155,  10'h2AA,  32'hAAAA_AAAA, 1'b0, NO_RESULT},
		'{10'd16,   10'd16,   10'd16,   32'hC0FF_EE00, 1'b0, NO_RESULT},
		'{10'd23,   10'd23,   10'd23,   32'h00FF_00FF, 1'b0, NO_RESULT},
		'{10'd120,  10'd120,  10'd0,    32'hFF00_FF00, 1'b0, NO_RESULT}
	};

	int unsigned phase_w     [N_PHASES] = '{16, 1, 0, 31, 16, 5, 16};
	int unsigned phase_h     [N_PHASES] = '{16, 1, 5, 31, 16, 16, 16};
	int unsigned phase_d     [N_PHASES] = '{16, 1, 16, 31, 16, 9, 1};
	int          phase_items [N_PHASES] = '{400, 40, 30, 150, 300, 130, 130};
	idle_mode_t  phase_mode  [N_PHASES] = '{IDLE_RECV_HEAVY, IDLE_RECV_HEAVY, IDLE_SEND_HEAVY,
		IDLE_SEND_HEAVY, IDLE_SEND_HEAVY, IDLE_NONE, IDLE_NONE};

	voxel_brick_map_insert_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.voxel_x      (voxel_x),
		.voxel_y      (voxel_y),
		.voxel_z      (voxel_z),
		.voxel_color  (voxel_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.brick_slot   (brick_slot),
		.new_brick    (new_brick),
		.fine_offset  (fine_offset),
		.total_voxels (total_voxels)
	);

	always #1 clk = ~clk;

	function automatic insert_result_t predict_insert(input logic [COORD_BITS-1:0] x, y, z);
		insert_result_t r;
		int unsigned bx, by, bz, cidx;
		r = '0;
		bx = x / BRICK_EDGE;
		by = y / BRICK_EDGE;
		bz = z / BRICK_EDGE;
		r.fine = FINE_W'(x % BRICK_EDGE + BRICK_EDGE * (y % BRICK_EDGE
			+ BRICK_EDGE * (z % BRICK_EDGE)));
		cidx = bx + grid_w * (by + grid_h * bz);
		if (bx >= grid_w || by >= grid_h || bz >= grid_d || cidx >= GRID_CELLS) begin
			r.status = ST_BOUNDS;
		end else if (!cell_taken[cidx] && slots_used >= POOL_BRICKS) begin
			r.status = ST_FULL;
		end else begin
			r.status = ST_STORED;
			if (!cell_taken[cidx]) begin
				cell_taken[cidx] = 1'b1;
				cell_slot[cidx] = SLOT_OUT_W'(slots_used);
				slots_used++;
				r.fresh = 1'b1;
			end
			r.slot = cell_slot[cidx];
			if (stored_count != '1)
				stored_count++;
		end
		r.tally = stored_count;
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] near_bound(input int unsigned g);
		int unsigned b;
		case ($urandom_range(0, 2))
			0: b = (g == 0) ? 0 : g - 1;
			1: b = g;
			default: b = $urandom_range(0, BRICK_TOP);
		endcase
		if (b > BRICK_TOP)
			b = BRICK_TOP;
		return COORD_BITS'(b * BRICK_EDGE + $urandom_range(0, BRICK_EDGE - 1));
	endfunction

	task automatic pick_voxel(output logic [COORD_BITS-1:0] x, y, z);
		voxel_pos_t v;
		int unsigned roll, fresh_lim, hot_lim, edge_lim, bx, by, bz, cidx, tries;
		bit found;
		fresh_lim = (slots_used >= POOL_BRICKS) ? 20 : 75;
		hot_lim = (slots_used >= POOL_BRICKS) ? 70 : 90;
		edge_lim = (slots_used >= POOL_BRICKS) ? 85 : 95;
		roll = $urandom_range(0, 99);
		if (roll < fresh_lim && grid_w != 0 && grid_h != 0 && grid_d != 0) begin
			found = 1'b0;
			tries = 0;
			while (!found && tries < 8) begin
				bx = $urandom_range(0, grid_w - 1);
				by = $urandom_range(0, grid_h - 1);
				bz = $urandom_range(0, grid_d - 1);
				cidx = bx + grid_w * (by + grid_h * bz);
				found = cidx < GRID_CELLS && !cell_taken[cidx];
				tries++;
			end
			x = COORD_BITS'(bx * BRICK_EDGE + $urandom_range(0, BRICK_EDGE - 1));
			y = COORD_BITS'(by * BRICK_EDGE + $urandom_range(0, BRICK_EDGE - 1));
			z = COORD_BITS'(bz * BRICK_EDGE + $urandom_range(0, BRICK_EDGE - 1));
		end else if (roll < hot_lim && recent_voxels.size() != 0) begin
			v = recent_voxels[$urandom_range(0, recent_voxels.size() - 1)];
			x = {v.x[COORD_BITS-1:BRICK_SHIFT], BRICK_SHIFT'($urandom())};
			y = {v.y[COORD_BITS-1:BRICK_SHIFT], BRICK_SHIFT'($urandom())};
			z = {v.z[COORD_BITS-1:BRICK_SHIFT], BRICK_SHIFT'($urandom())};
		end else if (roll < edge_lim) begin
			x = near_bound(grid_w);
			y = near_bound(grid_h);
			z = near_bound(grid_d);
		end else begin
			x = COORD_BITS'($urandom());
			y = COORD_BITS'($urandom());
			z = COORD_BITS'($urandom());
		end
	endtask

	task automatic send_voxel(input logic [COORD_BITS-1:0] x, y, z,
		input logic [COLOR_W-1:0] color, input logic by_hand, input insert_result_t hand_res);
		insert_result_t r;
		int gap;
		voxel_x <= x;
		voxel_y <= y;
		voxel_z <= z;
		voxel_color <= color;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		r = predict_insert(x, y, z);
		pending_results.insert(pending_results.size(), by_hand ? hand_res : r);
		if (r.status == ST_STORED) begin
			recent_voxels.insert(recent_voxels.size(), voxel_pos_t'{x, y, z});
			if (recent_voxels.size() > 8)
				void'(recent_voxels.pop_front());
		end
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_grid_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= GRID_REG_W'(value);
		@(posedge clk);
		case (idx)
			REG_GRID_X: grid_w = value % (1 << GRID_REG_W);
			REG_GRID_Y: grid_h = value % (1 << GRID_REG_W);
			REG_GRID_Z: grid_d = value % (1 << GRID_REG_W);
			default: ;
		endcase
	endtask

	task automatic set_idle_mode(input idle_mode_t m);
		case (m)
			IDLE_RECV_HEAVY: begin
				send_idle_pct = 9;
				recv_stall_pct <= 63;
			end
			IDLE_SEND_HEAVY: begin
				send_idle_pct = 63;
				recv_stall_pct <= 9;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct <= 0;
			end
		endcase
	endtask

	task automatic wait_for_drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		insert_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d, brick_slot %0d", status, brick_slot);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (brick_slot !== want.slot) begin
					$error("brick_slot: expected %0d, got %0d", want.slot, brick_slot);
					errors++;
				end
				if (new_brick !== want.fresh) begin
					$error("new_brick: expected %0d, got %0d", want.fresh, new_brick);
					errors++;
				end
				if (fine_offset !== want.fine) begin
					$error("fine_offset: expected %0d, got %0d", want.fine, fine_offset);
					errors++;
				end
				if (total_voxels !== want.tally) begin
					$error("total_voxels: expected %0d, got %0d", want.tally, total_voxels);
					errors++;
				end
			end
		end
	end

	initial begin
		voxel_case_t c;
		logic [COORD_BITS-1:0] x, y, z;
		int n;
		set_idle_mode(IDLE_RECV_HEAVY);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_CASES; i++) begin
			c = directed_cases[i];
			send_voxel(c.x, c.y, c.z, c.color, c.by_hand, c.res);
		end
		in_valid <= 1'b0;
		wait_for_drain();
		for (int p = 0; p < N_PHASES; p++) begin
			set_idle_mode(phase_mode[p]);
			write_grid_reg(REG_GRID_X, phase_w[p]);
			write_grid_reg(REG_GRID_Y, phase_h[p]);
			write_grid_reg(REG_GRID_Z, phase_d[p]);
			if (p == 0)
				write_grid_reg(REG_SPARE, 0);
			cfg_wr_en <= 1'b0;
			n = 0;
			while (n < phase_items[p]
				|| (p == FILL_PHASE && slots_used < POOL_BRICKS && n < 1000)) begin
				pick_voxel(x, y, z);
				send_voxel(x, y, z, $urandom(), 1'b0, NO_RESULT);
				n++;
			end
			in_valid <= 1'b0;
			wait_for_drain();
		end
		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== voxel_brick_map_insert_unit.f =====
+incdir+hdl
hdl/vbm_pkg.sv
hdl/vbm_front.sv
hdl/vbm_queue.sv
hdl/vbm_back.sv
hdl/voxel_brick_map_insert_unit.sv
tb/sv/tb_voxel_brick_map_insert_unit.sv
